// ----- rtl/var_pkg.sv -----
// Shared constants, types and angle table for the vector axis rotation block.
package var_pkg;

  localparam int TRIG_FRAC = 30;
  localparam int TRIG_W    = 34;
  localparam int FACT_W    = 32;
  localparam int ATAN_N    = 32;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [FACT_W-1:0] fact_t;

  localparam trig_t CORDIC_GAIN = 34'sd652032874;
  localparam trig_t TRIG_ONE    = 34'sd1073741824;

  localparam logic MODE_ABOUT_X = 1'b0;
  localparam logic MODE_ABOUT_Y = 1'b1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [31:0] PHASE_HALF_QUAD = 32'h2000_0000;

  // atan(2^-i), 2^32 per full turn
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

// ----- rtl/vector_axis_rotation.sv -----
// Pipelined rotation of a 3D fixed-point vector about the X or Y axis.
//
//  channel  | direction | ports                                        | handshake
//  ---------+-----------+----------------------------------------------+-----------------------
//  in_      | sink      | in_mode, in_coord_x/y/z, in_turn_angle       | in_valid / in_ready
//  out_     | source    | out_rot_x, out_rot_y, out_rot_z              | out_valid / out_ready
//
// One beat enters per cycle while the output register is not stalled; the pipeline is an entry
// register, the one-stage-per-iteration CORDIC, then clamp, multiply, sum and
// round/saturate stages.
// rst_n (synchronous) clears the stage valid bits only.
// A stalled output register freezes the whole pipeline; nothing is dropped or repeated.
module vector_axis_rotation #(
  parameter int COORD_WIDTH  = 32,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic signed [COORD_WIDTH-1:0] in_coord_z,
  input  logic [ANGLE_WIDTH-1:0]        in_turn_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_rot_x,
  output logic signed [COORD_WIDTH-1:0] out_rot_y,
  output logic signed [COORD_WIDTH-1:0] out_rot_z
);

  localparam int CW   = COORD_WIDTH;
  localparam int NS   = CORDIC_STEPS;
  localparam int TW   = var_pkg::TRIG_W;
  localparam int FW   = var_pkg::FACT_W;
  localparam int PHB  = CW - 15;
  localparam int PH_W = FW + PHB;
  localparam int PL_W = FW + 17;
  localparam int HS_W = PH_W + 1;
  localparam int LS_W = PL_W + 2;
  localparam int SUM_W = CW + 36;
  localparam int RW   = SUM_W - var_pkg::TRIG_FRAC;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [LS_W-1:0] ROUND_HALF = LS_W'(64'sd1 <<< (var_pkg::TRIG_FRAC - 1));

  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;

  // ---- entry: phase, quadrant and residual
  logic [31:0] phase;
  logic [31:0] phase_rnd;
  logic [1:0]  quad;
  logic [31:0] resid;

  always_comb begin
    phase     = {in_turn_angle, {(32-ANGLE_WIDTH){1'b0}}};
    phase_rnd = phase + var_pkg::PHASE_HALF_QUAD;
    quad      = phase_rnd[31:30];
    resid     = phase - {quad, 30'd0};
  end

  logic              c_vld_r  [0:NS];
  logic              c_mode_r [0:NS];
  coord_t            c_px_r   [0:NS];
  coord_t            c_py_r   [0:NS];
  coord_t            c_pz_r   [0:NS];
  logic [1:0]        c_quad_r [0:NS];
  var_pkg::trig_t    c_x_r    [0:NS];
  var_pkg::trig_t    c_y_r    [0:NS];
  var_pkg::trig_t    c_z_r    [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r[0] <= 1'b0;
    end else if (adv) begin
      c_vld_r[0] <= in_valid;
    end
    if (adv) begin
      c_mode_r[0] <= in_mode;
      c_px_r[0]   <= in_coord_x;
      c_py_r[0]   <= in_coord_y;
      c_pz_r[0]   <= in_coord_z;
      c_quad_r[0] <= quad;
      c_x_r[0]    <= var_pkg::CORDIC_GAIN;
      c_y_r[0]    <= '0;
      c_z_r[0]    <= TW'($signed(resid));
    end
  end

  // ---- CORDIC iterations, one stage each
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam var_pkg::trig_t ANG = TW'({1'b0, var_pkg::ATAN_TAB[i]});
    var_pkg::trig_t dx, dy, x_nxt, y_nxt, z_nxt;

    always_comb begin
      dx = c_y_r[i] >>> i;
      dy = c_x_r[i] >>> i;
      if (!c_z_r[i][TW-1]) begin
        x_nxt = c_x_r[i] - dx;
        y_nxt = c_y_r[i] + dy;
        z_nxt = c_z_r[i] - ANG;
      end else begin
        x_nxt = c_x_r[i] + dx;
        y_nxt = c_y_r[i] - dy;
        z_nxt = c_z_r[i] + ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        c_vld_r[i+1] <= c_vld_r[i];
      end
      if (adv) begin
        c_mode_r[i+1] <= c_mode_r[i];
        c_px_r[i+1]   <= c_px_r[i];
        c_py_r[i+1]   <= c_py_r[i];
        c_pz_r[i+1]   <= c_pz_r[i];
        c_quad_r[i+1] <= c_quad_r[i];
        c_x_r[i+1]    <= x_nxt;
        c_y_r[i+1]    <= y_nxt;
        c_z_r[i+1]    <= z_nxt;
      end
    end
  end

  // ---- clamp, quadrant turn and operand selection
  var_pkg::trig_t cl_x, cl_y, cos_v, sin_v, nsin_v;
  coord_t         sel_p, sel_q, sel_pass;

  always_comb begin
    cl_x = c_x_r[NS];
    if (c_x_r[NS] > var_pkg::TRIG_ONE) cl_x = var_pkg::TRIG_ONE;
    if (c_x_r[NS] < -var_pkg::TRIG_ONE) cl_x = -var_pkg::TRIG_ONE;
    cl_y = c_y_r[NS];
    if (c_y_r[NS] > var_pkg::TRIG_ONE) cl_y = var_pkg::TRIG_ONE;
    if (c_y_r[NS] < -var_pkg::TRIG_ONE) cl_y = -var_pkg::TRIG_ONE;
    case (c_quad_r[NS])
      var_pkg::QUAD_1: begin
        cos_v = -cl_y;
        sin_v = cl_x;
      end
      var_pkg::QUAD_2: begin
        cos_v = -cl_x;
        sin_v = -cl_y;
      end
      var_pkg::QUAD_3: begin
        cos_v = cl_y;
        sin_v = -cl_x;
      end
      default: begin
        cos_v = cl_x;
        sin_v = cl_y;
      end
    endcase
    nsin_v = -sin_v;
    if (c_mode_r[NS] == var_pkg::MODE_ABOUT_Y) begin
      sel_p    = c_pz_r[NS];
      sel_q    = c_px_r[NS];
      sel_pass = c_py_r[NS];
    end else begin
      sel_p    = c_py_r[NS];
      sel_q    = c_pz_r[NS];
      sel_pass = c_px_r[NS];
    end
  end

  logic          r_vld_r, r_mode_r;
  var_pkg::fact_t r_cos_r, r_sin_r, r_nsin_r;
  coord_t        r_p_r, r_q_r, r_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (adv) begin
      r_vld_r <= c_vld_r[NS];
    end
    if (adv) begin
      r_mode_r <= c_mode_r[NS];
      r_cos_r  <= FW'(cos_v);
      r_sin_r  <= FW'(sin_v);
      r_nsin_r <= FW'(nsin_v);
      r_p_r    <= sel_p;
      r_q_r    <= sel_q;
      r_pass_r <= sel_pass;
    end
  end

  // ---- partial products: coordinate split into signed high and 16-bit low parts
  logic signed [PHB-1:0] ph, qh;
  logic signed [16:0]    pl, ql;

  always_comb begin
    ph = PHB'(r_p_r >>> 16);
    qh = PHB'(r_q_r >>> 16);
    pl = $signed({1'b0, r_p_r[15:0]});
    ql = $signed({1'b0, r_q_r[15:0]});
  end

  logic                   m_vld_r, m_mode_r;
  coord_t                 m_pass_r;
  logic signed [PH_W-1:0] m_ahp_r, m_ahq_r, m_bhp_r, m_bhq_r;
  logic signed [PL_W-1:0] m_alp_r, m_alq_r, m_blp_r, m_blq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= r_vld_r;
    end
    if (adv) begin
      m_mode_r <= r_mode_r;
      m_pass_r <= r_pass_r;
      m_ahp_r  <= PH_W'(r_cos_r) * PH_W'(ph);
      m_ahq_r  <= PH_W'(r_nsin_r) * PH_W'(qh);
      m_bhp_r  <= PH_W'(r_sin_r) * PH_W'(ph);
      m_bhq_r  <= PH_W'(r_cos_r) * PH_W'(qh);
      m_alp_r  <= PL_W'(r_cos_r) * PL_W'(pl);
      m_alq_r  <= PL_W'(r_nsin_r) * PL_W'(ql);
      m_blp_r  <= PL_W'(r_sin_r) * PL_W'(pl);
      m_blq_r  <= PL_W'(r_cos_r) * PL_W'(ql);
    end
  end

  // ---- sums of high and low parts
  logic                   s_vld_r, s_mode_r;
  coord_t                 s_pass_r;
  logic signed [HS_W-1:0] s_ahi_r, s_bhi_r;
  logic signed [LS_W-1:0] s_alo_r, s_blo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (adv) begin
      s_vld_r <= m_vld_r;
    end
    if (adv) begin
      s_mode_r <= m_mode_r;
      s_pass_r <= m_pass_r;
      s_ahi_r  <= HS_W'(m_ahp_r) + HS_W'(m_ahq_r);
      s_bhi_r  <= HS_W'(m_bhp_r) + HS_W'(m_bhq_r);
      s_alo_r  <= LS_W'(m_alp_r) + LS_W'(m_alq_r) + ROUND_HALF;
      s_blo_r  <= LS_W'(m_blp_r) + LS_W'(m_blq_r) + ROUND_HALF;
    end
  end

  // ---- recombine, round, saturate
  logic signed [SUM_W-1:0] tot_a, tot_b;
  logic signed [RW-1:0]    rnd_a, rnd_b;
  coord_t                  sat_a, sat_b;
  coord_t                  rot_x_nxt, rot_y_nxt, rot_z_nxt;

  always_comb begin
    tot_a = (SUM_W'(s_ahi_r) <<< 16) + SUM_W'(s_alo_r);
    tot_b = (SUM_W'(s_bhi_r) <<< 16) + SUM_W'(s_blo_r);
    rnd_a = RW'(tot_a >>> var_pkg::TRIG_FRAC);
    rnd_b = RW'(tot_b >>> var_pkg::TRIG_FRAC);
    if (rnd_a > RW'(C_MAX)) begin
      sat_a = C_MAX;
    end else if (rnd_a < RW'(C_MIN)) begin
      sat_a = C_MIN;
    end else begin
      sat_a = CW'(rnd_a);
    end
    if (rnd_b > RW'(C_MAX)) begin
      sat_b = C_MAX;
    end else if (rnd_b < RW'(C_MIN)) begin
      sat_b = C_MIN;
    end else begin
      sat_b = CW'(rnd_b);
    end
    if (s_mode_r == var_pkg::MODE_ABOUT_Y) begin
      rot_x_nxt = sat_b;
      rot_y_nxt = s_pass_r;
      rot_z_nxt = sat_a;
    end else begin
      rot_x_nxt = s_pass_r;
      rot_y_nxt = sat_a;
      rot_z_nxt = sat_b;
    end
  end

  coord_t rot_x_r, rot_y_r, rot_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_vld_r;
    end
    if (adv) begin
      rot_x_r <= rot_x_nxt;
      rot_y_r <= rot_y_nxt;
      rot_z_r <= rot_z_nxt;
    end
  end

  assign out_rot_x = rot_x_r;
  assign out_rot_y = rot_y_r;
  assign out_rot_z = rot_z_r;

endmodule

// ----- rtl/var_checker.sv -----
// Port-level assertions for the vector axis rotation block, bound to its top level.
module var_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_rot_x,
  input logic [COORD_WIDTH-1:0] out_rot_y,
  input logic [COORD_WIDTH-1:0] out_rot_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rot_x) && $stable(out_rot_y)
      && $stable(out_rot_z))
    else $error("stalled output beat changed or vanished");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output register empty");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_accept_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !(out_valid && !out_ready && $past(out_valid && !out_ready)
      && in_ready))
    else $error("input accepted across a held stall");

endmodule

bind vector_axis_rotation var_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_var_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rot_x (out_rot_x),
  .out_rot_y (out_rot_y),
  .out_rot_z (out_rot_z)
);

// ----- tb/rotation_check_pkg.sv -----
// Scoreboard class and fixed-point rotation predictor for the vector axis rotation testbench.
`timescale 1ns / 100ps

package rotation_check_pkg;

  import var_pkg::*;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int STEPS   = 16;
  localparam int LATENCY = STEPS + 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ANGLE_W-1:0]        angle_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vector_t;

  localparam longint COORD_TOP = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_BOT = -COORD_TOP - 1;

  class rotation_scoreboard;

    vector_t     pending_vectors[$];
    int unsigned mismatches = 0;

    function void trig_of_angle(input angle_t angle, output longint c, output longint s);
      logic [31:0]        phase;
      logic [31:0]        resid;
      logic signed [31:0] resid_s;
      logic [1:0]         quad;
      longint             x, y, z, t, dx, dy;
      phase   = 32'(angle) << (32 - ANGLE_W);
      quad    = 2'((phase + PHASE_HALF_QUAD) >> 30);
      resid   = phase - {quad, 30'b0};
      resid_s = resid;
      z = resid_s;
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(ATAN_TAB[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(ATAN_TAB[i]);
        end
      end
      if (x > TRIG_ONE) x = TRIG_ONE;
      if (x < -TRIG_ONE) x = -TRIG_ONE;
      if (y > TRIG_ONE) y = TRIG_ONE;
      if (y < -TRIG_ONE) y = -TRIG_ONE;
      case (quad)
        QUAD_1: begin
          t = x;
          x = -y;
          y = t;
        end
        QUAD_2: begin
          x = -x;
          y = -y;
        end
        QUAD_3: begin
          t = x;
          x = y;
          y = -t;
        end
        default: ;
      endcase
      c = x;
      s = y;
    endfunction

    // round half up of (f1*p + f2*q) / 2^30, then saturate
    function coord_t weighted_pair(longint f1, longint p, longint f2, longint q);
      longint acc;
      acc = f1 * p + f2 * q + (longint'(1) <<< (TRIG_FRAC - 1));
      acc = acc >>> TRIG_FRAC;
      if (acc > COORD_TOP) acc = COORD_TOP;
      if (acc < COORD_BOT) acc = COORD_BOT;
      return coord_t'(acc);
    endfunction

    function vector_t rotate_vector(logic m, coord_t x, coord_t y, coord_t z, angle_t a);
      longint  c, s;
      vector_t r;
      trig_of_angle(a, c, s);
      r.x = x;
      r.y = y;
      r.z = z;
      if (m == MODE_ABOUT_X) begin
        r.y = weighted_pair(c, y, -s, z);
        r.z = weighted_pair(s, y, c, z);
      end else begin
        r.z = weighted_pair(c, z, -s, x);
        r.x = weighted_pair(s, z, c, x);
      end
      return r;
    endfunction

    function void note_input(logic m, coord_t x, coord_t y, coord_t z, angle_t a);
      pending_vectors.push_back(rotate_vector(m, x, y, z, a));
    endfunction

    function void check_result(coord_t x, coord_t y, coord_t z);
      vector_t e;
      if (pending_vectors.size() == 0) begin
        $error("unexpected output beat: rot_x=%0d rot_y=%0d rot_z=%0d", x, y, z);
        mismatches++;
        return;
      end
      e = pending_vectors.pop_front();
      if (x !== e.x) begin
        $error("rot_x: expected %0d, actual %0d", e.x, x);
        mismatches++;
      end
      if (y !== e.y) begin
        $error("rot_y: expected %0d, actual %0d", e.y, y);
        mismatches++;
      end
      if (z !== e.z) begin
        $error("rot_z: expected %0d, actual %0d", e.z, z);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// ----- tb/vector_axis_rotation_tb.sv -----
// Top-level testbench: drives rotation beats, stalls the output and checks every result.
`timescale 1ns / 100ps

module vector_axis_rotation_tb;

  import var_pkg::*;
  import rotation_check_pkg::*;

  localparam int     RANDOM_ITEMS = 1400;
  localparam int     QUIET_ITEMS  = 150;
  localparam int     LONG_HOLD    = 300;
  localparam int     HOLD_AT      = 400;
  localparam coord_t C_MAX        = coord_t'(32'h7FFF_FFFF);
  localparam coord_t C_MIN        = coord_t'(32'h8000_0000);
  localparam coord_t C_ONE        = coord_t'(32'h0001_0000);

  logic   clk           = 1'b0;
  logic   rst_n         = 1'b0;
  logic   in_valid      = 1'b0;
  logic   in_ready;
  logic   in_mode       = 1'b0;
  coord_t in_coord_x    = '0;
  coord_t in_coord_y    = '0;
  coord_t in_coord_z    = '0;
  angle_t in_turn_angle = '0;
  logic   out_valid;
  logic   out_ready     = 1'b0;
  coord_t out_rot_x;
  coord_t out_rot_y;
  coord_t out_rot_z;

  rotation_scoreboard board;
  int unsigned        accepted_inputs = 0;
  bit                 quiet           = 1'b0;
  bit                 held_off        = 1'b0;
  int                 calm_left       = 0;

  vector_axis_rotation #(
    .COORD_WIDTH  (COORD_W),
    .ANGLE_WIDTH  (ANGLE_W),
    .CORDIC_STEPS (STEPS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_turn_angle (in_turn_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rot_x     (out_rot_x),
    .out_rot_y     (out_rot_y),
    .out_rot_z     (out_rot_z)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    board = new();
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      board.note_input(in_mode, in_coord_x, in_coord_y, in_coord_z, in_turn_angle);
      accepted_inputs++;
    end
    if (rst_n && out_valid && out_ready)
      board.check_result(out_rot_x, out_rot_y, out_rot_z);
  end

  task automatic send_vector(input logic m, input coord_t x, input coord_t y, input coord_t z,
                             input angle_t a);
    int gap;
    gap = 0;
    if (!quiet) begin
      if (calm_left > 0)
        calm_left--;
      else if ($urandom_range(0, 9) == 0)
        calm_left = $urandom_range(20, 60);
      else if ($urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_coord_z    <= z;
    in_turn_angle <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      3: return coord_t'($signed($urandom_range(0, 2)) - 32'sd1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic angle_t pick_angle();
    if ($urandom_range(0, 7) == 0)
      return angle_t'(($urandom_range(0, 7) << 13) + $urandom_range(0, 2) - 1);
    return angle_t'($urandom);
  endfunction

  // drop ready in bursts, once for a long stretch so the pipeline backs up
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (!held_off && accepted_inputs >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_vector(MODE_ABOUT_X, 0, 0, 0, 16'h0000);
    send_vector(MODE_ABOUT_X, 1, -1, 1, 16'h0000);
    send_vector(MODE_ABOUT_X, C_MAX, C_MIN, C_MAX, 16'h0000);
    send_vector(MODE_ABOUT_Y, C_MIN, C_MAX, C_MIN, 16'hFFFF);
    send_vector(MODE_ABOUT_X, 12345, C_MAX, C_MAX, 16'h2000);
    send_vector(MODE_ABOUT_X, -777, C_MIN, C_MIN, 16'h2000);
    send_vector(MODE_ABOUT_Y, C_MAX, 4242, C_MAX, 16'h2000);
    send_vector(MODE_ABOUT_Y, C_MIN, -99, C_MIN, 16'hE000);
    send_vector(MODE_ABOUT_X, C_ONE, C_ONE, C_ONE, 16'h4000);
    send_vector(MODE_ABOUT_Y, C_ONE, C_ONE, C_ONE, 16'h4000);
    send_vector(MODE_ABOUT_X, C_ONE, -C_ONE, C_ONE, 16'h8000);
    send_vector(MODE_ABOUT_Y, -C_ONE, C_ONE, C_ONE, 16'hC000);
    send_vector(MODE_ABOUT_X, 5, C_ONE, -C_ONE, 16'h1FFF);
    send_vector(MODE_ABOUT_Y, C_ONE, 7, -C_ONE, 16'h6000);
    send_vector(MODE_ABOUT_X, 3, 32'sh0012_3456, 32'sh00AB_CDEF, 16'hA000);
    send_vector(MODE_ABOUT_Y, 32'sh0012_3456, 3, 32'sh00AB_CDEF, 16'h2001);
    send_vector(MODE_ABOUT_X, 0, 1, 0, 16'h2AAB);
    send_vector(MODE_ABOUT_Y, -1, 0, 1, 16'h0001);
    send_vector(MODE_ABOUT_X, C_MIN, C_MIN, C_MIN, 16'h7FFF);
    send_vector(MODE_ABOUT_Y, C_MIN, C_MAX, 0, 16'h8000);
    send_vector(MODE_ABOUT_X, C_MAX, C_MIN, 0, 16'h8000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS)
        quiet = 1'b1;
      send_vector(1'($urandom), pick_coord(), pick_coord(), pick_coord(), pick_angle());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (board.pending_vectors.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- vector_axis_rotation.f -----
rtl/var_pkg.sv
rtl/vector_axis_rotation.sv
rtl/var_checker.sv
tb/rotation_check_pkg.sv
tb/vector_axis_rotation_tb.sv
